[rtl/bsom_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the bucket shift-or matcher.
package bsom_pkg;

  // Operation codes carried by each input word
  typedef enum logic [1:0] {
    OP_CLEAR   = 2'd0,
    OP_PATTERN = 2'd1,
    OP_SCAN    = 2'd2
  } op_t;

  localparam int LEN_W     = 7;
  localparam int CHAR_W    = 8;
  localparam int POS_W     = 6;
  localparam int START_W   = 32;
  localparam int CFG_DATA_W = 32;

  // Register index of the pattern length register
  localparam logic REG_PATTERN_LENGTH = 1'b0;

  // Mask table command from the processing stage
  typedef struct packed {
    logic clear;      // set every mask back to all ones
    logic set_bit;    // clear one position bit of one character mask
  } mask_cmd_t;

endpackage

[rtl/bsom_mask_mem.sv]
`timescale 1ns / 1ps
// Character mask table: memory with one read and one write port, per-entry valid bits and write forwarding.
module bsom_mask_mem #(
  parameter int ALPHABET    = 256,
  parameter int MAX_PATTERN = 64
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          rd_en,
  input  logic [$clog2(ALPHABET)-1:0]   rd_addr,
  input  bsom_pkg::mask_cmd_t           cmd,
  input  logic [$clog2(ALPHABET)-1:0]   proc_addr,
  input  logic [bsom_pkg::POS_W-1:0]    proc_pos,
  output logic [MAX_PATTERN-1:0]        mask
);
  import bsom_pkg::*;

  logic [MAX_PATTERN-1:0] mem [ALPHABET];
  logic [MAX_PATTERN-1:0] rdata_r;
  logic                   byp_r;
  logic [MAX_PATTERN-1:0] byp_data_r;
  logic [ALPHABET-1:0]    valid_r;
  logic [ALPHABET-1:0]    valid_nxt;
  logic [MAX_PATTERN-1:0] wdata;
  logic [MAX_PATTERN-1:0] stored;

  // Entry as seen by the item now in the processing stage
  assign stored = byp_r ? byp_data_r : rdata_r;
  assign mask   = valid_r[proc_addr] ? stored : '1;
  assign wdata  = mask & ~({{(MAX_PATTERN-1){1'b0}}, 1'b1} << proc_pos);

  always_ff @(posedge clk) begin
    if (cmd.set_bit) begin
      mem[proc_addr] <= wdata;
    end
    if (rd_en) begin
      rdata_r    <= mem[rd_addr];
      byp_data_r <= wdata;
    end
  end

  always_comb begin
    valid_nxt = valid_r;
    if (cmd.clear) begin
      valid_nxt = '0;
    end else if (cmd.set_bit) begin
      valid_nxt[proc_addr] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      byp_r   <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      // forward a write that lands in the same cycle as the read
      if (rd_en) begin
        byp_r <= cmd.set_bit && (proc_addr == rd_addr);
      end
    end
  end

endmodule

[rtl/bsom_scan.sv]
`timescale 1ns / 1ps
// Shift-or match vector, buffer offset and first-match tracking.
module bsom_scan #(
  parameter int MAX_PATTERN = 64,
  parameter int OFFSET_BITS = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          step,
  input  logic                          last,
  input  logic [MAX_PATTERN-1:0]        mask,
  input  logic [bsom_pkg::LEN_W-1:0]    pattern_length,
  output logic                          hit,
  output logic [OFFSET_BITS-1:0]        start
);
  import bsom_pkg::*;

  localparam int VW = $clog2(MAX_PATTERN + 1);

  logic [MAX_PATTERN:0]   vec_r;
  logic [MAX_PATTERN:0]   vec_nxt;
  logic [OFFSET_BITS-1:0] offset_r;
  logic [OFFSET_BITS-1:0] offset_inc;
  logic                   found_r;
  logic                   len_ok;
  logic                   zero_at_len;

  assign vec_nxt     = {vec_r[MAX_PATTERN-1:0] | mask, 1'b0};
  assign len_ok      = (pattern_length != '0) && (int'(pattern_length) <= MAX_PATTERN);
  assign zero_at_len = len_ok && !vec_nxt[pattern_length[VW-1:0]];
  assign hit         = zero_at_len && !found_r;
  assign offset_inc  = offset_r + OFFSET_BITS'(1);
  assign start       = hit ? (offset_inc - OFFSET_BITS'(pattern_length)) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vec_r    <= {{MAX_PATTERN{1'b1}}, 1'b0};
      offset_r <= '0;
      found_r  <= 1'b0;
    end else if (step) begin
      if (last) begin
        // end of buffer: restart vector, offset and first-match flag
        vec_r    <= {{MAX_PATTERN{1'b1}}, 1'b0};
        offset_r <= '0;
        found_r  <= 1'b0;
      end else begin
        vec_r    <= vec_nxt;
        offset_r <= offset_inc;
        found_r  <= found_r | hit;
      end
    end
  end

endmodule

[rtl/bucket_shift_or_matcher.sv]
`timescale 1ns / 1ps
// Top level of the bucket shift-or matcher: handshakes, register port and pipeline.
//
// Input channel (in_*): one word per accepted item carries an operation
// (clear masks, pattern byte, scan byte), a character, a pattern position
// and a last flag. Result channel (out_*): exactly one word per input word,
// in order; out_match is 1 only on the byte that ends the first match of a
// buffer, and out_match_start then gives the buffer offset where it began.
// Register port (APB style, pready tied high): pattern_length at address 0;
// write it only while the block is empty.
// An accepted word passes the input stage register and then the result register
// before out_valid rises; one word is taken every cycle while in_stall is low.
// The mask table read happens on acceptance, its registered data feeds
// the single processing stage, which writes the result register.
// When out_stall is high the result register holds, the processing stage
// fills, and in_stall rises only once both are occupied.
// Reset (rst_n low, synchronous) empties the pipeline, sets every character
// mask to all ones, restarts the match vector and offset, and sets
// pattern_length to 0.
module bucket_shift_or_matcher #(
  parameter int ALPHABET    = 256,
  parameter int MAX_PATTERN = 64,
  parameter int OFFSET_BITS = 32
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [1:0]                         in_operation,
  input  logic [bsom_pkg::CHAR_W-1:0]        in_char_value,
  input  logic [bsom_pkg::POS_W-1:0]         in_pattern_position,
  input  logic                               in_last,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic                               out_match,
  output logic [bsom_pkg::START_W-1:0]       out_match_start,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic                               paddr,
  input  logic [bsom_pkg::CFG_DATA_W-1:0]    pwdata,
  output logic [bsom_pkg::CFG_DATA_W-1:0]    prdata,
  output logic                               pready
);
  import bsom_pkg::*;

  localparam int AW = $clog2(ALPHABET);

  logic                   accept;
  logic                   out_free;
  logic                   advance;

  logic                   s1_valid_r;
  op_t                    s1_op_r;
  logic [CHAR_W-1:0]      s1_ch_r;
  logic [POS_W-1:0]       s1_pos_r;
  logic                   s1_last_r;

  logic                   out_valid_r;
  logic                   out_match_r;
  logic [START_W-1:0]     out_match_start_r;

  logic [LEN_W-1:0]       cfg_len_r;

  mask_cmd_t              cmd;
  logic                   step;
  logic                   ch_ok;
  logic                   pos_ok;
  logic [MAX_PATTERN-1:0] table_mask;
  logic [MAX_PATTERN-1:0] scan_mask;
  logic                   hit;
  logic [OFFSET_BITS-1:0] start;

  // handshakes
  assign out_free = !out_valid_r || !out_stall;
  assign advance  = s1_valid_r && out_free;
  assign in_stall = s1_valid_r && !out_free;
  assign accept   = in_valid && !in_stall;

  // register port
  assign pready = 1'b1;
  assign prdata = (paddr == REG_PATTERN_LENGTH) ? CFG_DATA_W'(cfg_len_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_len_r <= '0;
    end else if (psel && penable && pwrite && pready && (paddr == REG_PATTERN_LENGTH)) begin
      cfg_len_r <= pwdata[LEN_W-1:0];
    end
  end

  // input stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (accept) begin
      s1_valid_r <= 1'b1;
    end else if (advance) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_op_r   <= op_t'(in_operation);
      s1_ch_r   <= in_char_value;
      s1_pos_r  <= in_pattern_position;
      s1_last_r <= in_last;
    end
  end

  assign ch_ok  = int'(s1_ch_r) < ALPHABET;
  assign pos_ok = int'(s1_pos_r) < MAX_PATTERN;

  // decode the word leaving the input stage
  always_comb begin
    cmd  = '0;
    step = 1'b0;
    case (s1_op_r)
      OP_CLEAR: begin
        cmd.clear = advance;
      end
      OP_PATTERN: begin
        cmd.set_bit = advance && ch_ok && pos_ok;
      end
      OP_SCAN: begin
        step = advance;
      end
      default: begin
        cmd  = '0;
        step = 1'b0;
      end
    endcase
  end

  bsom_mask_mem #(
    .ALPHABET   (ALPHABET),
    .MAX_PATTERN(MAX_PATTERN)
  ) u_mask_mem (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_en    (accept),
    .rd_addr  (in_char_value[AW-1:0]),
    .cmd      (cmd),
    .proc_addr(s1_ch_r[AW-1:0]),
    .proc_pos (s1_pos_r),
    .mask     (table_mask)
  );

  // characters outside the alphabet match nowhere
  assign scan_mask = ch_ok ? table_mask : '1;

  bsom_scan #(
    .MAX_PATTERN(MAX_PATTERN),
    .OFFSET_BITS(OFFSET_BITS)
  ) u_scan (
    .clk           (clk),
    .rst_n         (rst_n),
    .step          (step),
    .last          (s1_last_r),
    .mask          (scan_mask),
    .pattern_length(cfg_len_r),
    .hit           (hit),
    .start         (start)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_match_r       <= step && hit;
      out_match_start_r <= step ? START_W'(start) : '0;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_match       = out_match_r;
  assign out_match_start = out_match_start_r;

  // a held word moves on whenever the result register frees
  a_advance: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && out_free |=> out_valid_r)
    else $error("input stage word not moved to result register");

  // a disabled pattern length never reports a match
  a_len_zero: assert property (@(posedge clk) disable iff (!rst_n)
    advance && (cfg_len_r == '0) |=> !out_match_r)
    else $error("match reported with pattern length zero");

  // start offset is zero on words without a match
  a_start_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_match_r |-> out_match_start_r == '0)
    else $error("nonzero match start without a match");

endmodule
